FILE: rtl/core/fir_pkg.sv
package fir_pkg;

    localparam int MAX_TAPS_DEF = 32;

    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 5;
    localparam int VALUE_W   = 16;
    localparam int TAPS_W    = 6;
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = 2 * VALUE_W;

    localparam logic [TAPS_W-1:0] TAP_COUNT_RST = TAPS_W'(32);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/core/fir_if.sv
interface fir_in_if;
    logic                             valid;
    logic                             ready;
    logic [fir_pkg::ACTION_W-1:0]     action;
    logic [fir_pkg::INDEX_W-1:0]      coeff_index;
    logic signed [fir_pkg::VALUE_W-1:0] value;
    logic                             block_end;

    modport source (output valid, action, coeff_index, value, block_end, input ready);
    modport sink   (input valid, action, coeff_index, value, block_end, output ready);
endinterface

interface fir_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fir_pkg::VALUE_W-1:0] filtered;
    logic                               saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

interface fir_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fir_pkg::TAPS_W-1:0]  tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

FILE: rtl/core/fir_filter.sv
// Channel   Dir  Payload                                   Transaction
// i_in      in   action, coeff_index, value, block_end     valid & ready
// o_out     out  filtered, saturated                       valid & ready
// i_cfg     in   tap_count                                 valid & ready (ready held high)
//
// A coefficient load, a history clear, or a sample that gives no result completes as it is taken.
// A sample that gives a result is worked out over the n taps in use: one shared 16x16
// multiply-accumulate walks the taps, one history/coefficient read per cycle, followed
// by the drain of its pipeline and one rounding step.
// Reset (synchronous, active low) clears the coefficient valid bits and the fill count,
// and returns tap_count to 32.
// The history memory needs no clearing; the fill count guards every read of it.
// A result waits in the output register; the next transaction is taken meanwhile, but the
// rounding step holds until the output register is free.
module fir_filter #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fir_in_if.sink          i_in,
    fir_out_if.source       o_out,
    fir_cfg_if.sink         i_cfg
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW     = $clog2(MAX_TAPS + 1);
    localparam int NW     = (CW > fir_pkg::TAPS_W) ? CW : fir_pkg::TAPS_W;
    localparam int ACC_W  = fir_pkg::PROD_W + AW;
    localparam int VW     = fir_pkg::VALUE_W;
    localparam int IW     = fir_pkg::INDEX_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1 << (fir_pkg::FRAC_BITS - 1));

    // Storage
    logic signed [VW-1:0] coef_mem [MAX_TAPS];
    logic signed [VW-1:0] hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]  r_coef_vld;

    // Control
    fir_pkg::t_state r_state, n_state;
    logic [fir_pkg::TAPS_W-1:0] r_tap;
    logic [CW-1:0]  r_fill;
    logic [AW-1:0]  r_wp;
    logic [CW-1:0]  r_n;
    logic [AW-1:0]  r_rd_addr;
    logic [CW-1:0]  r_rd_cnt;
    logic           r_p1_v;
    logic           r_p2_v;

    // Datapath
    logic signed [VW-1:0]     r_hist_q;
    logic signed [VW-1:0]     r_coef_q;
    logic                     r_coef_ok;
    logic signed [fir_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [VW-1:0]     r_filtered;
    logic                     r_sat;

    // Decoded signals
    logic           in_rdy;
    logic           rd_en;
    logic           fin_en;
    logic           in_acc;
    logic           out_free;
    logic [NW-1:0]  tap_w;
    logic [CW-1:0]  n_use;
    logic [CW-1:0]  nm1;
    logic [CW-1:0]  fill_inc;
    logic           produce;
    logic [AW:0]    start_sum;
    logic [AW-1:0]  start_addr;
    logic [AW+IW-1:0] cidx_w;
    logic [AW-1:0]  coef_waddr;
    logic           coef_in_range;
    logic signed [VW-1:0]     coef_eff;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_sh;

    assign in_acc   = i_in.valid && in_rdy;
    assign out_free = !r_out_valid || o_out.ready;

    // Clamp the tap count to 1 .. MAX_TAPS
    always_comb begin
        tap_w = NW'(r_tap);
        if (tap_w == '0) begin
            n_use = CW'(1);
        end else if (tap_w > NW'(MAX_TAPS)) begin
            n_use = CW'(MAX_TAPS);
        end else begin
            n_use = CW'(tap_w);
        end
    end

    assign nm1      = n_use - CW'(1);
    assign fill_inc = (r_fill < CW'(MAX_TAPS)) ? (r_fill + CW'(1)) : r_fill;
    assign produce  = (fill_inc >= n_use);

    // Oldest sample of the window: newest slot minus (n - 1), wrapped
    always_comb begin
        start_sum = (AW+1)'(r_wp) + (AW+1)'(MAX_TAPS) - (AW+1)'(nm1);
        if (start_sum >= (AW+1)'(MAX_TAPS)) begin
            start_addr = AW'(start_sum - (AW+1)'(MAX_TAPS));
        end else begin
            start_addr = AW'(start_sum);
        end
    end

    assign cidx_w        = (AW+IW)'(i_in.coeff_index);
    assign coef_waddr    = cidx_w[AW-1:0];
    assign coef_in_range = (cidx_w < (AW+IW)'(MAX_TAPS));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_pkg::ST_IDLE: begin
                if (in_acc && i_in.action == fir_pkg::ACT_SAMPLE && produce) begin
                    n_state = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN: begin
                if (r_rd_cnt + CW'(1) >= r_n) begin
                    n_state = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = fir_pkg::ST_FINISH;
                end
            end
            fir_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = fir_pkg::ST_IDLE;
                end
            end
            default: n_state = fir_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_rdy = 1'b0;
        rd_en  = 1'b0;
        fin_en = 1'b0;
        unique case (r_state)
            fir_pkg::ST_IDLE:   in_rdy = 1'b1;
            fir_pkg::ST_RUN:    rd_en  = (r_rd_cnt < r_n);
            fir_pkg::ST_DRAIN:  ;
            fir_pkg::ST_FINISH: fin_en = out_free;
            default:            ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fir_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= fir_pkg::TAP_COUNT_RST;
        end else if (i_cfg.valid) begin
            r_tap <= i_cfg.tap_count;
        end
    end

    // Fill count, write pointer and window set-up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_wp      <= '0;
            r_n       <= CW'(1);
            r_rd_addr <= '0;
            r_rd_cnt  <= '0;
        end else begin
            if (in_acc) begin
                case (i_in.action)
                    fir_pkg::ACT_CLEAR: r_fill <= '0;
                    fir_pkg::ACT_SAMPLE: begin
                        // block end drops the history once this sample is in the window
                        r_fill    <= i_in.block_end ? '0 : fill_inc;
                        r_wp      <= (r_wp == AW'(MAX_TAPS - 1)) ? '0 : (r_wp + AW'(1));
                        r_n       <= n_use;
                        r_rd_addr <= start_addr;
                        r_rd_cnt  <= '0;
                    end
                    default: ;
                endcase
            end
            if (rd_en) begin
                r_rd_addr <= (r_rd_addr == AW'(MAX_TAPS - 1)) ? '0 : (r_rd_addr + AW'(1));
                r_rd_cnt  <= r_rd_cnt + CW'(1);
            end
        end
    end

    // History memory: newest sample at the slot the write pointer held
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.action == fir_pkg::ACT_SAMPLE) begin
            hist_mem[r_wp] <= i_in.value;
        end
        if (rd_en) begin
            r_hist_q <= hist_mem[r_rd_addr];
        end
    end

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.action == fir_pkg::ACT_LOAD && coef_in_range) begin
            coef_mem[coef_waddr] <= i_in.value;
        end
        if (rd_en) begin
            r_coef_q  <= coef_mem[r_rd_cnt[AW-1:0]];
            r_coef_ok <= r_coef_vld[r_rd_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (in_acc && i_in.action == fir_pkg::ACT_LOAD && coef_in_range) begin
            r_coef_vld[coef_waddr] <= 1'b1;
        end
    end

    // Shared multiply-accumulate
    assign coef_eff = r_coef_ok ? r_coef_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_p1_v <= rd_en;
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_v) begin
            r_prod <= r_hist_q * coef_eff;
        end
        if (in_acc) begin
            r_acc <= '0;
        end else if (r_p2_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then clip to 16 bits
    assign rnd_sum = r_acc + RND;
    assign rnd_sh  = rnd_sum >>> fir_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (fin_en) begin
            if (rnd_sh > SAT_HI) begin
                r_filtered <= VW'(SAT_HI);
                r_sat      <= 1'b1;
            end else if (rnd_sh < SAT_LO) begin
                r_filtered <= VW'(SAT_LO);
                r_sat      <= 1'b1;
            end else begin
                r_filtered <= VW'(rnd_sh);
                r_sat      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_en) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready      = in_rdy;
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.filtered  = r_filtered;
    assign o_out.saturated = r_sat;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_TAPS))
        else $error("fill count above depth");

    a_reads_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fir_pkg::ST_RUN |-> (r_rd_cnt < r_n && r_n <= CW'(MAX_TAPS)))
        else $error("tap walk overran window");

    a_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fir_pkg::ST_IDLE |-> (!r_p1_v && !r_p2_v))
        else $error("multiply pipeline busy while idle");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_en |=> (r_out_valid && r_state == fir_pkg::ST_IDLE))
        else $error("rounded result not presented");

endmodule

FILE: tb/fir_filter_tb.sv
`timescale 1ns / 1ps

module fir_filter_tb;

    localparam int CLK_HALF      = 6;
    localparam int LIMIT_CYCLES  = 400_000;
    // a sample that gives a result walks every tap in use before the result appears
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 120;
    localparam int N_PHASES      = 10;
    localparam int DIR_ROWS      = 25;
    localparam int ERR_PRINT_MAX = 40;

    // action 3 is not decoded by the block
    localparam logic [fir_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // receiver stall patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_COIN   = 1;
    localparam int RDY_MASK   = 2;
    localparam int RDY_SPARSE = 3;

    typedef struct packed {
        logic [fir_pkg::VALUE_W-1:0] filtered;
        logic                        saturated;
    } t_fir_result;

    typedef struct packed {
        bit                           is_cfg;
        logic [fir_pkg::TAPS_W-1:0]   taps;
        logic [fir_pkg::ACTION_W-1:0] action;
        logic [fir_pkg::INDEX_W-1:0]  idx;
        logic [fir_pkg::VALUE_W-1:0]  value;
        logic                         blk;
        bit                           typed;
        t_fir_result                  typed_res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    fir_in_if  in_ch ();
    fir_out_if out_ch ();
    fir_cfg_if cfg_ch ();

    fir_filter #(
        .MAX_TAPS (fir_pkg::MAX_TAPS_DEF)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // mirror of the filter state
    logic [fir_pkg::VALUE_W-1:0] coef_mirror [fir_pkg::MAX_TAPS_DEF];
    logic [fir_pkg::VALUE_W-1:0] hist_mirror [fir_pkg::MAX_TAPS_DEF];
    int                          fill_mirror;
    logic [fir_pkg::TAPS_W-1:0]  taps_mirror;

    t_fir_result pending_outputs [$];

    int err_count    = 0;
    int results_seen = 0;
    int n_samples    = 0;
    int n_loads      = 0;
    int n_clears     = 0;
    int n_noise      = 0;
    int n_tap_writes = 0;
    int cycles       = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;
    bit hold_req     = 1'b0;

    t_stim_row dir_tab [DIR_ROWS];

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_outputs.size());
            $display("fir_filter test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < ERR_PRINT_MAX)
            $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int taps_in_use();
        if (taps_mirror == 0)
            return 1;
        if (taps_mirror > fir_pkg::MAX_TAPS_DEF)
            return fir_pkg::MAX_TAPS_DEF;
        return int'(taps_mirror);
    endfunction

    function automatic void reset_history();
        foreach (hist_mirror[k])
            hist_mirror[k] = '0;
        fill_mirror = 0;
    endfunction

    // advance the mirror by one transaction; return 1 when a result is due
    function automatic bit predict_fir_output(input logic [fir_pkg::ACTION_W-1:0] act,
                                              input logic [fir_pkg::INDEX_W-1:0] idx,
                                              input logic [fir_pkg::VALUE_W-1:0] val,
                                              input logic blk,
                                              output t_fir_result res);
        longint acc;
        longint rounded;
        int     n;
        int     k;
        bit     produced;
        produced = 1'b0;
        res = '0;
        case (act)
            fir_pkg::ACT_LOAD: coef_mirror[idx] = val;
            fir_pkg::ACT_CLEAR: reset_history();
            fir_pkg::ACT_SAMPLE: begin
                n = taps_in_use();
                for (k = fir_pkg::MAX_TAPS_DEF - 1; k > 0; k--)
                    hist_mirror[k] = hist_mirror[k-1];
                hist_mirror[0] = val;
                if (fill_mirror < fir_pkg::MAX_TAPS_DEF)
                    fill_mirror++;
                if (fill_mirror >= n) begin
                    // window runs oldest first against coefficient 0
                    acc = 0;
                    for (k = 0; k < n; k++)
                        acc += longint'($signed(hist_mirror[n-1-k]))
                             * longint'($signed(coef_mirror[k]));
                    rounded = (acc + 64'sd16384) >>> fir_pkg::FRAC_BITS;
                    if (rounded > 32767) begin
                        res.filtered  = 16'h7FFF;
                        res.saturated = 1'b1;
                    end else if (rounded < -32768) begin
                        res.filtered  = 16'h8000;
                        res.saturated = 1'b1;
                    end else begin
                        res.filtered  = rounded[fir_pkg::VALUE_W-1:0];
                    end
                    produced = 1'b1;
                end
                if (blk)
                    reset_history();
            end
            default: ;
        endcase
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offer one transaction and hold it until the block takes it
    task automatic send_item(input logic [fir_pkg::ACTION_W-1:0] act,
                             input logic [fir_pkg::INDEX_W-1:0] idx,
                             input logic [fir_pkg::VALUE_W-1:0] val, input logic blk);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.coeff_index <= idx;
        in_ch.value       <= val;
        in_ch.block_end   <= blk;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
    endtask

    task automatic apply_item(input logic [fir_pkg::ACTION_W-1:0] act,
                              input logic [fir_pkg::INDEX_W-1:0] idx,
                              input logic [fir_pkg::VALUE_W-1:0] val, input logic blk,
                              input bit typed, input t_fir_result typed_res);
        t_fir_result res;
        bit          due;
        send_item(act, idx, val, blk);
        due = predict_fir_output(act, idx, val, blk, res);
        if (typed) begin
            res = typed_res;
            due = 1'b1;
        end
        if (due)
            pending_outputs.push_back(res);
        case (act)
            fir_pkg::ACT_LOAD:   n_loads++;
            fir_pkg::ACT_SAMPLE: n_samples++;
            fir_pkg::ACT_CLEAR:  n_clears++;
            default:             n_noise++;
        endcase
    endtask

    // drop valid and hold off until every result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending_outputs.size() != 0);
    endtask

    // write tap_count only once the block has gone idle
    task automatic write_tap_count(input logic [fir_pkg::TAPS_W-1:0] taps);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.tap_count <= taps;
        do
            @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        taps_mirror = taps;
        n_tap_writes++;
    endtask

    function automatic logic [fir_pkg::VALUE_W-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return {{8{r[7]}}, r[7:0]};
            default: return r[fir_pkg::VALUE_W-1:0];
        endcase
    endfunction

    // load the coefficients in use, then mostly stream samples with some
    // reloads, clears, block ends and undecoded actions mixed in
    task automatic random_phase(input int n_items);
        int done;
        int k;
        int pick;
        for (k = 0; k < taps_in_use(); k++)
            apply_item(fir_pkg::ACT_LOAD, fir_pkg::INDEX_W'(k), rand_sample(),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        done = taps_in_use();
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                apply_item(fir_pkg::ACT_LOAD,
                           fir_pkg::INDEX_W'($urandom_range(0, fir_pkg::MAX_TAPS_DEF - 1)),
                           rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
                done++;
            end else if (pick < 9) begin
                apply_item(fir_pkg::ACT_CLEAR, fir_pkg::INDEX_W'($urandom), rand_sample(),
                           1'($urandom_range(0, 1)), 1'b0, '0);
                done++;
            end else if (pick < 12) begin
                apply_item(ACT_UNUSED, fir_pkg::INDEX_W'($urandom), rand_sample(),
                           1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                apply_item(fir_pkg::ACT_SAMPLE, fir_pkg::INDEX_W'($urandom), rand_sample(),
                           1'($urandom_range(0, 39) == 0), 1'b0, '0);
                done++;
            end
        end
    endtask

    function automatic t_stim_row cfg_row(input logic [fir_pkg::TAPS_W-1:0] taps);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.taps   = taps;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [fir_pkg::ACTION_W-1:0] act,
                                           input logic [fir_pkg::INDEX_W-1:0] idx,
                                           input logic [fir_pkg::VALUE_W-1:0] val,
                                           input logic blk, input bit typed,
                                           input logic [fir_pkg::VALUE_W-1:0] t_filt,
                                           input logic t_sat);
        t_stim_row r;
        r = '0;
        r.action              = act;
        r.idx                 = idx;
        r.value               = val;
        r.blk                 = blk;
        r.typed               = typed;
        r.typed_res.filtered  = t_filt;
        r.typed_res.saturated = t_sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // output side: check each transaction, then pick the next ready
    // ------------------------------------------------------------------
    initial begin : result_sink
        t_fir_result want;
        int          mode;
        int          mode_left;
        int          hold_left;
        logic [7:0]  mask;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        mask      = 8'b1011_0110;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                results_seen++;
                if (pending_outputs.size() == 0) begin
                    report_mismatch("result with nothing pending, filtered",
                                    int'($signed(out_ch.filtered)), 0);
                end else begin
                    want = pending_outputs.pop_front();
                    if (out_ch.filtered !== want.filtered)
                        report_mismatch("filtered", int'($signed(out_ch.filtered)),
                                        int'($signed(want.filtered)));
                    if (out_ch.saturated !== want.saturated)
                        report_mismatch("saturated", int'(out_ch.saturated),
                                        int'(want.saturated));
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS: out_ch.ready <= 1'b1;
                    RDY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_MASK: begin
                        out_ch.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int r;
        int ph;
        int tap_plan [N_PHASES];

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= fir_pkg::ACT_LOAD;
        in_ch.coeff_index <= '0;
        in_ch.value       <= '0;
        in_ch.block_end   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.tap_count  <= '0;

        foreach (coef_mirror[k])
            coef_mirror[k] = '0;
        reset_history();
        taps_mirror = fir_pkg::TAP_COUNT_RST;

        // a tap count of 0 acts as one tap: the extremes read straight off
        dir_tab[0]  = cfg_row(6'd0);
        dir_tab[1]  = item_row(fir_pkg::ACT_LOAD,   5'd0,  16'h8000, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[2]  = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h8000, 1'b0, 1'b1,
                               16'h7FFF, 1'b1);
        dir_tab[3]  = item_row(fir_pkg::ACT_SAMPLE, 5'd9,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[4]  = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h0000, 1'b0, 1'b1,
                               16'h0000, 1'b0);
        dir_tab[5]  = item_row(fir_pkg::ACT_LOAD,   5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[6]  = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        // block end clears the history after the sample is used
        dir_tab[7]  = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h8000, 1'b1, 1'b0, '0, 1'b0);
        // undecoded action and block end on a load: both ignored
        dir_tab[8]  = item_row(ACT_UNUSED,          5'd31, 16'hFFFF, 1'b1, 1'b0, '0, 1'b0);
        dir_tab[9]  = item_row(fir_pkg::ACT_LOAD,   5'd31, 16'h1234, 1'b1, 1'b0, '0, 1'b0);
        dir_tab[10] = cfg_row(6'd4);
        dir_tab[11] = item_row(fir_pkg::ACT_LOAD,   5'd1,  16'h4000, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[12] = item_row(fir_pkg::ACT_LOAD,   5'd2,  16'hC000, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[13] = item_row(fir_pkg::ACT_LOAD,   5'd3,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        // window not yet full, then a clear part way through filling
        dir_tab[14] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'd1000, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[15] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  -16'sd1000, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[16] = item_row(fir_pkg::ACT_CLEAR,  5'd21, 16'h5A5A, 1'b1, 1'b0, '0, 1'b0);
        dir_tab[17] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[18] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[19] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        dir_tab[20] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0, 1'b0);
        // shrink the window with history held: it counts toward the fill
        dir_tab[21] = cfg_row(6'd2);
        dir_tab[22] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'h8000, 1'b1, 1'b0, '0, 1'b0);
        dir_tab[23] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'd5,    1'b0, 1'b0, '0, 1'b0);
        dir_tab[24] = item_row(fir_pkg::ACT_SAMPLE, 5'd0,  16'd7,    1'b0, 1'b0, '0, 1'b0);

        // reset value, out-of-range values and both extremes among them
        tap_plan = '{32, 63, 1, 0, 2, 33, 7, 16, 31, 0};
        tap_plan[N_PHASES-1] = $urandom_range(0, 63);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].is_cfg)
                write_tap_count(dir_tab[r].taps);
            else
                apply_item(dir_tab[r].action, dir_tab[r].idx, dir_tab[r].value,
                           dir_tab[r].blk, dir_tab[r].typed, dir_tab[r].typed_res);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_tap_count(fir_pkg::TAPS_W'(tap_plan[ph]));
            steady = (ph % 3 == 2);
            // one tap gives fast results: stall the receiver long enough for
            // the block to back up into its input
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == 4) begin
                random_phase(PHASE_ITEMS / 2);
                drain_results();
                random_phase(PHASE_ITEMS / 2);
            end else begin
                random_phase(PHASE_ITEMS);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples, %0d coefficient loads, %0d clears, %0d ignored actions",
                 n_samples, n_loads, n_clears, n_noise);
        $display("Checked %0d filter outputs across %0d tap count writes in %0d cycles",
                 results_seen, n_tap_writes, cycles);
        if (err_count == 0 && pending_outputs.size() == 0)
            $display("fir_filter test passed");
        else
            $display("fir_filter test failed");
        $finish;
    end

endmodule
